FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms with a clock and an active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/acbt_pkg.sv
// ---------------------------------------------------------------------------
// Alarm chime buzzer timer package
// Item types, register codes and timing constants of the block.
// ---------------------------------------------------------------------------
`default_nettype none

package acbt_pkg;

  localparam int unsigned ALARMS_DEFAULT = 2;
  localparam int unsigned ALARMS_MAX     = 2;

  localparam logic [10:0] CHIME_TICKS = 11'd500;
  localparam logic [10:0] ALARM_TICKS = 11'd2000;
  localparam logic [3:0]  TONE_DIVIDE = 4'd10;
  localparam logic [15:0] NO_STAMP    = 16'hFFFF;
  localparam logic [15:0] MIN_PER_DAY  = 16'd1440;
  localparam logic [15:0] MIN_PER_HOUR = 16'd60;

  localparam int unsigned CFG_ADDR_W = 5;

  localparam logic       RST_CHIME_ON   = 1'b1;
  localparam logic       RST_MASTER_ON  = 1'b1;
  localparam logic [4:0] RST_A0_HOUR    = 5'd7;
  localparam logic [5:0] RST_A0_MINUTE  = 6'd0;
  localparam logic       RST_A0_ON      = 1'b1;
  localparam logic [4:0] RST_A1_HOUR    = 5'd12;
  localparam logic [5:0] RST_A1_MINUTE  = 6'd0;
  localparam logic       RST_A1_ON      = 1'b0;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_TIME = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    REG_CHIME_ON      = 3'd0,
    REG_MASTER_ON     = 3'd1,
    REG_A0_HOUR       = 3'd2,
    REG_A0_MINUTE     = 3'd3,
    REG_A0_ON         = 3'd4,
    REG_A1_HOUR       = 3'd5,
    REG_A1_MINUTE     = 3'd6,
    REG_A1_ON         = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic       opcode;
    logic [5:0] now_second;
    logic [5:0] now_minute;
    logic [4:0] now_hour;
    logic [4:0] now_day;
  } in_item_t;

  typedef struct packed {
    logic        buzzer_level;
    logic        beeping;
    logic [10:0] ticks_left;
    logic        chime_started;
    logic [1:0]  alarms_fired;
  } out_item_t;

endpackage

`default_nettype wire

FILE: src/acbt_in_if.sv
// ---------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying one tick or time update item.
// ---------------------------------------------------------------------------
`default_nettype none

interface acbt_in_if;
  import acbt_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

FILE: src/acbt_out_if.sv
// ---------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying one buzzer and alarm status item.
// ---------------------------------------------------------------------------
`default_nettype none

interface acbt_out_if;
  import acbt_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

FILE: src/alarm_chime_buzzer_timer.sv
// ---------------------------------------------------------------------------
// Alarm chime buzzer timer
// Beep countdown with tone divider, hourly chime and two minute alarms.
// ---------------------------------------------------------------------------
// Items arrive on in_chan: a 2 ms tick or a time update. Each item gives
// exactly one result on out_chan with the buzzer level, the remaining beep
// ticks and the chime and alarm flags of that item.
// An accepted item is held in an input register; the next-state logic runs
// when it moves into the result register, which then offers the result. One
// item is accepted per cycle while results are taken, and the block updates
// its state once per item in order.
// When the receiver stalls, the result register holds its item and the input
// register fills; ready then drops until the result is taken.
// Registers are written over the APB port at byte address 4*index; pready is
// always high and reads return the stored value.
// Synchronous reset clears the beep, tone and buzzer state, marks both alarms
// as never fired and loads the register reset values.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module alarm_chime_buzzer_timer #(
  parameter int unsigned ALARMS = acbt_pkg::ALARMS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  acbt_in_if.sink                              in_chan,
  acbt_out_if.source                           out_chan,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [acbt_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);
  import acbt_pkg::*;

  logic       chime_on_r;
  logic       master_on_r;
  logic [4:0] alarm_hour_r   [ALARMS_MAX];
  logic [5:0] alarm_minute_r [ALARMS_MAX];
  logic       alarm_on_r     [ALARMS_MAX];

  logic        s1_valid_r;
  in_item_t    s1_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r;

  logic [10:0] beep_left_r, beep_left_nxt;
  logic [3:0]  tone_div_r, tone_div_nxt;
  logic        buzzer_r, buzzer_nxt;
  logic [15:0] stamp_r   [ALARMS];
  logic [15:0] stamp_nxt [ALARMS];

  logic        chimed;
  logic [1:0]  fired;
  logic [3:0]  tone_inc;
  logic [15:0] stamp;
  logic        s1_adv;
  logic        cfg_wr;
  cfg_reg_t    cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign out_chan.valid = out_valid_r;
  assign out_chan.item  = out_item_r;

  always_comb begin
    unique case (cfg_sel)
      REG_CHIME_ON:  prdata = 32'(chime_on_r);
      REG_MASTER_ON: prdata = 32'(master_on_r);
      REG_A0_HOUR:   prdata = 32'(alarm_hour_r[0]);
      REG_A0_MINUTE: prdata = 32'(alarm_minute_r[0]);
      REG_A0_ON:     prdata = 32'(alarm_on_r[0]);
      REG_A1_HOUR:   prdata = 32'(alarm_hour_r[1]);
      REG_A1_MINUTE: prdata = 32'(alarm_minute_r[1]);
      REG_A1_ON:     prdata = 32'(alarm_on_r[1]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chime_on_r        <= RST_CHIME_ON;
      master_on_r       <= RST_MASTER_ON;
      alarm_hour_r[0]   <= RST_A0_HOUR;
      alarm_minute_r[0] <= RST_A0_MINUTE;
      alarm_on_r[0]     <= RST_A0_ON;
      alarm_hour_r[1]   <= RST_A1_HOUR;
      alarm_minute_r[1] <= RST_A1_MINUTE;
      alarm_on_r[1]     <= RST_A1_ON;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_CHIME_ON:  chime_on_r        <= pwdata[0];
        REG_MASTER_ON: master_on_r       <= pwdata[0];
        REG_A0_HOUR:   alarm_hour_r[0]   <= pwdata[4:0];
        REG_A0_MINUTE: alarm_minute_r[0] <= pwdata[5:0];
        REG_A0_ON:     alarm_on_r[0]     <= pwdata[0];
        REG_A1_HOUR:   alarm_hour_r[1]   <= pwdata[4:0];
        REG_A1_MINUTE: alarm_minute_r[1] <= pwdata[5:0];
        REG_A1_ON:     alarm_on_r[1]     <= pwdata[0];
      endcase
    end
  end

  assign tone_inc = tone_div_r + 4'd1;
  assign stamp    = 16'(s1_item_r.now_day) * MIN_PER_DAY
                  + 16'(s1_item_r.now_hour) * MIN_PER_HOUR
                  + 16'(s1_item_r.now_minute);

  always_comb begin
    beep_left_nxt = beep_left_r;
    tone_div_nxt  = tone_div_r;
    buzzer_nxt    = buzzer_r;
    stamp_nxt     = stamp_r;
    chimed        = 1'b0;
    fired         = 2'b00;
    if (opcode_t'(s1_item_r.opcode) == OP_TICK) begin
      if (beep_left_r != 11'd0) begin
        beep_left_nxt = beep_left_r - 11'd1;
        if (tone_inc >= TONE_DIVIDE) begin
          tone_div_nxt = 4'd0;
          buzzer_nxt   = !buzzer_r;
        end else begin
          tone_div_nxt = tone_inc;
        end
      end else begin
        tone_div_nxt = 4'd0;
        buzzer_nxt   = 1'b0;
      end
    end else if (s1_item_r.now_second == 6'd0) begin
      if (chime_on_r && s1_item_r.now_minute == 6'd0) begin
        chimed = 1'b1;
        if (CHIME_TICKS > beep_left_nxt) begin
          beep_left_nxt = CHIME_TICKS;
        end
      end
      if (master_on_r) begin
        for (int i = 0; i < ALARMS; i++) begin
          if (alarm_on_r[i] && s1_item_r.now_hour == alarm_hour_r[i] &&
              s1_item_r.now_minute == alarm_minute_r[i] && stamp_r[i] != stamp) begin
            stamp_nxt[i] = stamp;
            fired[i]     = 1'b1;
            if (ALARM_TICKS > beep_left_nxt) begin
              beep_left_nxt = ALARM_TICKS;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      beep_left_r <= 11'd0;
      tone_div_r  <= 4'd0;
      buzzer_r    <= 1'b0;
      for (int i = 0; i < ALARMS; i++) begin
        stamp_r[i] <= NO_STAMP;
      end
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        beep_left_r <= beep_left_nxt;
        tone_div_r  <= tone_div_nxt;
        buzzer_r    <= buzzer_nxt;
        stamp_r     <= stamp_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_item_r <= in_chan.item;
    end
    if (s1_adv) begin
      out_item_r.buzzer_level  <= buzzer_nxt;
      out_item_r.beeping       <= beep_left_nxt != 11'd0;
      out_item_r.ticks_left    <= beep_left_nxt;
      out_item_r.chime_started <= chimed;
      out_item_r.alarms_fired  <= fired;
    end
  end

  `ASSERT_SAME(a_tone_range, clk, rst_n, 1'b1, tone_div_r < TONE_DIVIDE)
  `ASSERT_NEXT(a_idle_tick_quiet, clk, rst_n,
               s1_adv && s1_item_r.opcode == OP_TICK && beep_left_r == 11'd0,
               !buzzer_r && tone_div_r == 4'd0)
  `ASSERT_NEXT(a_fire_extends, clk, rst_n, s1_adv && fired != 2'b00,
               beep_left_r == ALARM_TICKS && out_item_r.ticks_left == ALARM_TICKS)
  `ASSERT_SAME(a_no_overrun, clk, rst_n, s1_valid_r && !s1_adv, !in_chan.ready)
  `ASSERT_NEXT(a_stamp_kept, clk, rst_n, s1_adv && fired[0], stamp_r[0] == $past(stamp))

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// ---------------------------------------------------------------------------
// Alarm chime buzzer timer testbench
// Drives ticks and time updates through the input channel, rewrites the
// chime and alarm registers over APB between phases, and checks every
// status item against a cycle-free model of the beep counter, tone divider,
// chime and alarm logic kept in this file.
// ---------------------------------------------------------------------------
module testbench;
  import acbt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_AT     = 150;
  localparam int unsigned HOLD_LEN    = 60;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  acbt_in_if  in_if();
  acbt_out_if out_if();

  alarm_chime_buzzer_timer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Register shadow and beep state of the model.
  logic [31:0] reg_file [8];
  logic [10:0] beep_remaining;
  logic [3:0]  tone_count;
  logic        buzzer_q;
  logic [15:0] fired_stamp [2];

  in_item_t    pending_events [$];
  out_item_t   due_status [$];
  out_item_t   status_want;
  int unsigned total_sent;
  int unsigned results_seen = 0;
  int unsigned failures     = 0;
  int unsigned in_gap       = 0;
  int unsigned out_gap      = 0;
  bit          hold_on      = 1'b0;
  bit          steady;

  function automatic out_item_t apply_event(in_item_t ev);
    out_item_t   r;
    logic [15:0] stamp;
    logic [4:0]  a_hour;
    logic [5:0]  a_min;
    logic        a_on;
    r = '0;
    if (ev.opcode == OP_TICK) begin
      if (beep_remaining != 0) begin
        beep_remaining = beep_remaining - 11'd1;
        tone_count = tone_count + 4'd1;
        if (tone_count >= TONE_DIVIDE) begin
          tone_count = '0;
          buzzer_q   = ~buzzer_q;
        end
      end else begin
        buzzer_q   = 1'b0;
        tone_count = '0;
      end
    end else if (ev.now_second == 0) begin
      if (reg_file[REG_CHIME_ON][0] && ev.now_minute == 0) begin
        if (CHIME_TICKS > beep_remaining) beep_remaining = CHIME_TICKS;
        r.chime_started = 1'b1;
      end
      if (reg_file[REG_MASTER_ON][0]) begin
        stamp = ev.now_day * MIN_PER_DAY + ev.now_hour * MIN_PER_HOUR + ev.now_minute;
        for (int k = 0; k < 2; k++) begin
          a_hour = reg_file[k == 0 ? REG_A0_HOUR : REG_A1_HOUR][4:0];
          a_min  = reg_file[k == 0 ? REG_A0_MINUTE : REG_A1_MINUTE][5:0];
          a_on   = reg_file[k == 0 ? REG_A0_ON : REG_A1_ON][0];
          if (a_on && ev.now_hour == a_hour && ev.now_minute == a_min &&
              fired_stamp[k] != stamp) begin
            fired_stamp[k] = stamp;
            if (ALARM_TICKS > beep_remaining) beep_remaining = ALARM_TICKS;
            r.alarms_fired[k] = 1'b1;
          end
        end
      end
    end
    r.buzzer_level = buzzer_q;
    r.beeping      = (beep_remaining != 0);
    r.ticks_left   = beep_remaining;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    failures++;
  endtask

  // Input driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.item  <= '0;
    end else begin
      if (in_if.valid && in_if.ready) due_status.push_back(apply_event(in_if.item));
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_events.size() != 0) begin
          in_if.valid <= 1'b1;
          in_if.item  <= pending_events.pop_front();
          if (!steady && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 5);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver stall once the first stretch of results has been taken.
  initial begin
    wait (results_seen == HOLD_AT);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (due_status.size() == 0) begin
          $display("%0t ns: unexpected status item, expected none, actual %h",
                   $time, out_if.item);
          failures++;
        end else begin
          status_want = due_status.pop_front();
          if (out_if.item.buzzer_level !== status_want.buzzer_level)
            flag_mismatch("buzzer_level", status_want.buzzer_level, out_if.item.buzzer_level);
          if (out_if.item.beeping !== status_want.beeping)
            flag_mismatch("beeping", status_want.beeping, out_if.item.beeping);
          if (out_if.item.ticks_left !== status_want.ticks_left)
            flag_mismatch("ticks_left", status_want.ticks_left, out_if.item.ticks_left);
          if (out_if.item.chime_started !== status_want.chime_started)
            flag_mismatch("chime_started", status_want.chime_started,
                          out_if.item.chime_started);
          if (out_if.item.alarms_fired !== status_want.alarms_fired)
            flag_mismatch("alarms_fired", status_want.alarms_fired, out_if.item.alarms_fired);
        end
      end
      if (hold_on) begin
        out_if.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!steady && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 5);
      end
    end
  end

  task automatic apb_access(input logic wr, input cfg_reg_t r, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
    logic [31:0] unused;
    apb_access(1'b1, r, v, unused);
    reg_file[r] = v;
  endtask

  task automatic check_regs();
    logic [31:0] rdata;
    for (int i = 0; i < 8; i++) begin
      apb_access(1'b0, cfg_reg_t'(i), '0, rdata);
      if (rdata !== reg_file[i]) flag_mismatch("register readback", reg_file[i], rdata);
    end
  endtask

  task automatic load_random_settings(input bit same_time);
    logic [4:0] hr;
    logic [5:0] mn;
    write_reg(REG_CHIME_ON, $urandom_range(0, 1));
    write_reg(REG_MASTER_ON, 32'($urandom_range(0, 3) != 0));
    for (int k = 0; k < 2; k++) begin
      if (!(same_time && k == 1)) begin
        hr = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(24, 31))
                                         : 5'($urandom_range(0, 23));
        mn = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(60, 63))
                                         : 6'($urandom_range(0, 59));
      end
      write_reg(k == 0 ? REG_A0_HOUR : REG_A1_HOUR, 32'(hr));
      write_reg(k == 0 ? REG_A0_MINUTE : REG_A1_MINUTE, 32'(mn));
      write_reg(k == 0 ? REG_A0_ON : REG_A1_ON, 32'($urandom_range(0, 3) != 0));
    end
  endtask

  task automatic add_tick();
    in_item_t ev;
    ev = in_item_t'($urandom);
    ev.opcode = OP_TICK;
    pending_events.push_back(ev);
    total_sent++;
  endtask

  task automatic add_time(input logic [5:0] s, input logic [5:0] m, input logic [4:0] h,
                          input logic [4:0] d);
    in_item_t ev;
    ev.opcode     = OP_TIME;
    ev.now_second = s;
    ev.now_minute = m;
    ev.now_hour   = h;
    ev.now_day    = d;
    pending_events.push_back(ev);
    total_sent++;
  endtask

  // Mostly well-formed updates aimed at the alarm times and the top of the hour.
  task automatic add_random_event();
    logic [5:0] s;
    logic [5:0] m;
    logic [4:0] h;
    logic [4:0] d;
    if ($urandom_range(0, 99) < 45) begin
      add_tick();
    end else begin
      s = ($urandom_range(0, 3) != 0) ? 6'd0 : 6'($urandom_range(0, 63));
      d = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 3));
      case ($urandom_range(0, 4))
        0: begin
          h = reg_file[REG_A0_HOUR][4:0];
          m = reg_file[REG_A0_MINUTE][5:0];
        end
        1: begin
          h = reg_file[REG_A1_HOUR][4:0];
          m = reg_file[REG_A1_MINUTE][5:0];
        end
        2: begin
          h = 5'($urandom_range(0, 23));
          m = 6'd0;
        end
        3: begin
          h = 5'($urandom_range(0, 31));
          m = 6'($urandom_range(0, 63));
        end
        default: begin
          h = 5'($urandom_range(0, 23));
          m = 6'($urandom_range(0, 59));
        end
      endcase
      add_time(s, m, h, d);
    end
  endtask

  task automatic wait_idle();
    while (results_seen != total_sent) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  initial begin
    int unsigned ticks_sent;
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    steady       = 1'b0;
    total_sent   = 0;
    reg_file[REG_CHIME_ON]  = 32'(RST_CHIME_ON);
    reg_file[REG_MASTER_ON] = 32'(RST_MASTER_ON);
    reg_file[REG_A0_HOUR]   = 32'(RST_A0_HOUR);
    reg_file[REG_A0_MINUTE] = 32'(RST_A0_MINUTE);
    reg_file[REG_A0_ON]     = 32'(RST_A0_ON);
    reg_file[REG_A1_HOUR]   = 32'(RST_A1_HOUR);
    reg_file[REG_A1_MINUTE] = 32'(RST_A1_MINUTE);
    reg_file[REG_A1_ON]     = 32'(RST_A1_ON);
    beep_remaining = '0;
    tone_count     = '0;
    buzzer_q       = 1'b0;
    fired_stamp[0] = NO_STAMP;
    fired_stamp[1] = NO_STAMP;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    check_regs();

    // Quiet buzzer, updates off the minute, out-of-range times, then the chime.
    add_tick();
    add_time(6'd59, 6'd0, 5'd7, 5'd1);
    add_time(6'd63, 6'd63, 5'd31, 5'd31);
    add_time(6'd0, 6'd63, 5'd31, 5'd31);
    add_time(6'd0, 6'd0, 5'd31, 5'd0);
    add_time(6'd0, 6'd0, 5'd12, 5'd5);
    add_tick();

    // Let the chime beep run out completely, with stray updates mixed in.
    ticks_sent = 0;
    while (ticks_sent < 502) begin
      if ($urandom_range(0, 29) == 0) begin
        add_time(6'($urandom_range(1, 63)), 6'($urandom_range(0, 63)),
                 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
      end else begin
        add_tick();
        ticks_sent++;
      end
    end
    wait_idle();

    // First alarm with chime, the same minute again, then a new day.
    add_time(6'd0, 6'd0, 5'd7, 5'd1);
    add_time(6'd0, 6'd0, 5'd7, 5'd1);
    add_time(6'd0, 6'd0, 5'd7, 5'd2);
    repeat (12) add_tick();
    add_time(6'd30, 6'd0, 5'd7, 5'd2);
    wait_idle();

    write_reg(REG_CHIME_ON, 32'd0);
    write_reg(REG_MASTER_ON, 32'd1);
    write_reg(REG_A0_HOUR, 32'd23);
    write_reg(REG_A0_MINUTE, 32'd59);
    write_reg(REG_A0_ON, 32'd1);
    write_reg(REG_A1_HOUR, 32'd0);
    write_reg(REG_A1_MINUTE, 32'd0);
    write_reg(REG_A1_ON, 32'd1);
    check_regs();
    repeat (10) add_random_event();
    wait_idle();

    write_reg(REG_CHIME_ON, 32'd1);
    write_reg(REG_MASTER_ON, 32'd0);
    write_reg(REG_A0_HOUR, 32'd31);
    write_reg(REG_A0_MINUTE, 32'd63);
    write_reg(REG_A0_ON, 32'd0);
    write_reg(REG_A1_HOUR, 32'd24);
    write_reg(REG_A1_MINUTE, 32'd60);
    check_regs();
    repeat (10) add_random_event();
    wait_idle();

    load_random_settings(1'b1);
    write_reg(REG_MASTER_ON, 32'd1);
    repeat (10) add_random_event();
    wait_idle();

    load_random_settings(1'b0);
    check_regs();
    steady = 1'b1;
    repeat (10) add_random_event();
    wait_idle();

    if (due_status.size() != 0) begin
      $display("%0t ns: %0d status items expected but never seen", $time, due_status.size());
      failures++;
    end
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

endmodule
